### hw/rtl/olv_pkg.sv
// Types and constants shared by the ordered value list cells and top level.
package olv_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned OUT_CNT_W   = 5;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Broadcast to every cell in the execute cycle.
    typedef struct packed {
        logic append;   // write the new value at the tail position
        logic remove;   // cells at or behind the first match take the next entry
    } t_cell_cmd;

endpackage

### hw/rtl/olv_cell.sv
// One list position: holds an entry, compares it, and shifts from its neighbor.
module olv_cell
    import olv_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,        // transaction accepted: register match
    input  logic [VALUE_W-1:0] i_cmp_value,
    input  logic [CNT_W-1:0]   i_count,
    input  t_cell_cmd          i_cmd,
    input  logic               i_at_or_after, // at or behind the first match
    input  logic [VALUE_W-1:0] i_new_value,
    input  logic [VALUE_W-1:0] i_next_entry,
    output logic [VALUE_W-1:0] o_entry,
    output logic               o_match
);

    logic [VALUE_W-1:0] r_entry;
    logic               r_match;
    logic               n_match;

    assign n_match = (i_cmp_value == r_entry) && (CNT_W'(IDX) < i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_load) begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (i_count == CNT_W'(IDX))) begin
            r_entry <= i_new_value;
        end else if (i_cmd.remove && i_at_or_after) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

### hw/rtl/ordered_value_list.sv
// Top level of the ordered value list: a chain of entry cells plus control.
//
// Slave channel: i_s_tuser carries the operation (append, search, delete
// first match, clear), i_s_tdata the 32-bit signed value. Master channel:
// one result transaction per input with found, entry count and status.
//
// A transaction is accepted, then executed: in the accept cycle every cell
// compares its entry with the incoming value and registers a match bit; in
// the execute cycle the lowest match is isolated with one DEPTH-bit negate,
// the cells at or behind it shift forward on a delete, the tail cell is
// written on an append, and the result is loaded into the output register;
// o_s_tready goes low on accept and stays low until the transaction has
// executed. A full list drops an append and reports status 1.
//
// If the receiver stalls, the result stays in the output register and the
// next transaction is accepted and compared, then waits in its execute
// cycle until the output register is free.
// Reset empties the list (count 0), drops any held result and leaves o_s_tready high.
module ordered_value_list
    import olv_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // [31:0] value
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // [1:0] op
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // [0] found, [5:1] entry_count, [6] status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic               r_busy;
    t_op                r_op;
    logic [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               r_out_found;
    logic               r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    logic               w_accept;
    logic               w_exec;
    logic [DEPTH-1:0]   w_match;
    logic [DEPTH-1:0]   w_neg;
    logic [DEPTH-1:0]   w_ge;
    logic               w_found;
    logic               w_full;
    logic               w_res_found;
    logic               w_res_status;
    t_cell_cmd          w_cmd;
    logic [VALUE_W-1:0] w_entry [DEPTH];

    assign o_s_tready = !r_busy;
    assign w_accept   = i_s_tvalid && !r_busy;
    assign w_exec     = r_busy && (!r_out_valid || i_m_tready);

    assign w_neg   = (~w_match) + DEPTH'(1);
    assign w_ge    = w_match | w_neg;
    assign w_found = |w_match;
    assign w_full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        w_cmd        = '0;
        n_count      = r_count;
        w_res_found  = 1'b0;
        w_res_status = 1'b0;
        case (r_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_res_status = 1'b1;
                end else begin
                    w_cmd.append = w_exec;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                w_res_found = w_found;
            end
            OP_DELETE: begin
                w_res_found = w_found;
                if (w_found) begin
                    w_cmd.remove = w_exec;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_next;
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        olv_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (w_accept),
            .i_cmp_value   (i_s_tdata[VALUE_W-1:0]),
            .i_count       (r_count),
            .i_cmd         (w_cmd),
            .i_at_or_after (w_ge[g]),
            .i_new_value   (r_value),
            .i_next_entry  (w_next),
            .o_entry       (w_entry[g]),
            .o_match       (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(i_s_tuser);
            r_value <= i_s_tdata[VALUE_W-1:0];
        end
        if (w_exec) begin
            r_out_found  <= w_res_found;
            r_out_status <= w_res_status;
            r_out_count  <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_status, OUT_CNT_W'(r_out_count), r_out_found};

endmodule
